// ===== hdl/shp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shp_pkg: shared types and constants for the dual token bucket shaper
// Item payloads, register map, operation and result codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package shp_pkg;

  // Field widths
  localparam int LEN_W   = 16;
  localparam int TAG_W   = 16;
  localparam int PTOK_W  = 20;
  localparam int BINC_W  = 40;
  localparam int BTOK_W  = 42;
  localparam int OVH_W   = 10;
  localparam int ENTRY_W = TAG_W + LEN_W;

  // APB map: one 64-bit register every 8 bytes
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [2:0] REG_PKT_ON   = 3'd0;
  localparam logic [2:0] REG_BYTE_ON  = 3'd1;
  localparam logic [2:0] REG_PKT_INC  = 3'd2;
  localparam logic [2:0] REG_BYTE_INC = 3'd3;
  localparam logic [2:0] REG_OVERHEAD = 3'd4;

  // Reset values of the registers
  localparam logic [PTOK_W-1:0] PKT_INC_RST  = 20'd1;
  localparam logic [BINC_W-1:0] BYTE_INC_RST = 40'd12500;

  // Smallest byte increment honored
  localparam logic [BINC_W-1:0] BYTE_INC_FLOOR = 40'd60;

  // Operation codes
  localparam logic [1:0] OP_ARRIVE    = 2'd0;
  localparam logic [1:0] OP_PKT_TICK  = 2'd1;
  localparam logic [1:0] OP_BYTE_TICK = 2'd2;
  localparam logic [1:0] OP_END       = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_EOS     = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [LEN_W-1:0] packet_length;
    logic [TAG_W-1:0] packet_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [TAG_W-1:0] out_tag;
    logic [LEN_W-1:0] out_length;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic              pkt_on;
    logic              byte_on;
    logic [PTOK_W-1:0] pkt_inc;
    logic [BINC_W-1:0] byte_inc;
    logic [OVH_W-1:0]  overhead;
  } shp_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture accepted item
    logic enqueue;     // write item into backlog
    logic emit_drop;   // output a drop result
    logic refill_pkt;
    logic refill_byte;
    logic mark_end;
    logic emit_eos;
    logic rel;         // release head of backlog
  } shp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       can_rel;      // buckets allow a release now
    logic       ended;
    logic       eos_pending;  // stream ended, end result not yet sent
    logic       slot_free;    // output register can take a result
  } shp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/shp_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shp_regs: APB configuration registers
// Five registers at 8-byte spacing; writes in the access phase, reads
// return the stored value. Unmapped addresses read zero and ignore writes.
// ----------------------------------------------------------------------------
module shp_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [shp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [shp_pkg::DATA_W-1:0]  pwdata,
  output logic      [shp_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output shp_pkg::shp_cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[shp_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pkt_on   <= 1'b1;
      cfg.byte_on  <= 1'b1;
      cfg.pkt_inc  <= shp_pkg::PKT_INC_RST;
      cfg.byte_inc <= shp_pkg::BYTE_INC_RST;
      cfg.overhead <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        shp_pkg::REG_PKT_ON:   cfg.pkt_on   <= pwdata[0];
        shp_pkg::REG_BYTE_ON:  cfg.byte_on  <= pwdata[0];
        shp_pkg::REG_PKT_INC:  cfg.pkt_inc  <= pwdata[shp_pkg::PTOK_W-1:0];
        shp_pkg::REG_BYTE_INC: cfg.byte_inc <= pwdata[shp_pkg::BINC_W-1:0];
        shp_pkg::REG_OVERHEAD: cfg.overhead <= pwdata[shp_pkg::OVH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      shp_pkg::REG_PKT_ON:   prdata[0] = cfg.pkt_on;
      shp_pkg::REG_BYTE_ON:  prdata[0] = cfg.byte_on;
      shp_pkg::REG_PKT_INC:  prdata[shp_pkg::PTOK_W-1:0] = cfg.pkt_inc;
      shp_pkg::REG_BYTE_INC: prdata[shp_pkg::BINC_W-1:0] = cfg.byte_inc;
      shp_pkg::REG_OVERHEAD: prdata[shp_pkg::OVH_W-1:0] = cfg.overhead;
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/shp_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shp_dp: shaper datapath
// Item capture, both token buckets, the backlog ring buffer and the
// result output register. Acts only on controller commands.
// ----------------------------------------------------------------------------
module shp_dp #(
  parameter int BACKLOG_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire shp_pkg::shp_cfg_t  cfg,
  input  wire shp_pkg::in_item_t  item,
  input  wire shp_pkg::shp_cmd_t  cmd,
  output shp_pkg::shp_sts_t       sts,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output shp_pkg::out_item_t      result
);

  localparam int AW = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
  localparam int CW = $clog2(BACKLOG_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(BACKLOG_DEPTH);
  localparam logic [AW:0]   DEPTH_T  = (AW+1)'(BACKLOG_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(BACKLOG_DEPTH - 1);

  // Captured item
  logic [1:0]                op;
  logic [shp_pkg::LEN_W-1:0] len;
  logic [shp_pkg::TAG_W-1:0] tag;

  // Bucket and backlog state
  logic        [shp_pkg::PTOK_W-1:0] ptok;
  logic signed [shp_pkg::BTOK_W-1:0] btok;
  logic        [AW-1:0]              head;
  logic        [AW-1:0]              head_next;
  logic        [CW-1:0]              count;
  logic                              ended;
  logic                              eos_sent;

  // Backlog memory, registered read of the head entry
  logic [shp_pkg::ENTRY_W-1:0] mem [BACKLOG_DEPTH];
  logic [shp_pkg::ENTRY_W-1:0] rd_data;
  logic [shp_pkg::ENTRY_W-1:0] wr_data;
  logic [AW:0]                 tail_sum;
  logic [AW-1:0]               tail;

  logic                              emit;
  logic                              pkt_ok;
  logic                              byte_ok;
  logic                              can_rel;
  logic [shp_pkg::LEN_W-1:0]         rd_len;
  logic [shp_pkg::TAG_W-1:0]         rd_tag;
  logic [shp_pkg::LEN_W:0]           charge;
  logic signed [shp_pkg::BTOK_W-1:0] btok_after;
  logic                              after_ok;
  logic                              rel_last;
  logic [shp_pkg::BINC_W-1:0]        binc_eff;
  logic signed [shp_pkg::BTOK_W-1:0] binc_s;
  logic [shp_pkg::PTOK_W-1:0]        pinc_eff;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= item.operation;
      len <= item.packet_length;
      tag <= item.packet_tag;
    end
  end

  // Tail position of the ring
  assign tail_sum = {1'b0, head} + {1'b0, count[AW-1:0]};
  assign tail     = (tail_sum >= DEPTH_T) ? AW'(tail_sum - DEPTH_T) : tail_sum[AW-1:0];
  assign wr_data  = {tag, len};

  assign head_next = !cmd.rel ? head : (head == LAST_IDX) ? '0 : head + 1'b1;

  // Memory: write on enqueue, read the next head with write-through
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      mem[tail] <= wr_data;
    end
    if (cmd.enqueue && (tail == head_next)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[head_next];
    end
  end

  assign rd_tag = rd_data[shp_pkg::ENTRY_W-1:shp_pkg::LEN_W];
  assign rd_len = rd_data[shp_pkg::LEN_W-1:0];

  // Release test and the state after a release
  assign pkt_ok     = !cfg.pkt_on || (ptok != '0);
  assign byte_ok    = !cfg.byte_on || (btok > 0);
  assign can_rel    = pkt_ok && byte_ok;
  assign charge     = {1'b0, rd_len} + (shp_pkg::LEN_W+1)'(cfg.overhead);
  assign btok_after = btok - $signed(shp_pkg::BTOK_W'(charge));
  assign after_ok   = (!cfg.pkt_on || (ptok != shp_pkg::PTOK_W'(1)))
                   && (!cfg.byte_on || (btok_after > 0));
  // Last if nothing can follow: more backlog but blocked, or empty with no end pending
  assign rel_last   = (count == CW'(1)) ? !(ended && !eos_sent) : !after_ok;

  // Effective increments
  assign pinc_eff = (cfg.pkt_inc == '0) ? shp_pkg::PTOK_W'(1) : cfg.pkt_inc;
  assign binc_eff = (cfg.byte_inc < shp_pkg::BYTE_INC_FLOOR) ? shp_pkg::BYTE_INC_FLOOR
                                                             : cfg.byte_inc;
  assign binc_s   = $signed({2'b00, binc_eff});

  // Buckets, backlog pointers and stream flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ptok     <= '0;
      btok     <= '0;
      head     <= '0;
      count    <= '0;
      ended    <= 1'b0;
      eos_sent <= 1'b0;
    end else begin
      head <= head_next;
      if (cmd.enqueue) begin
        count <= count + 1'b1;
      end else if (cmd.rel) begin
        count <= count - 1'b1;
      end
      // A tick always lands at the increment when the bucket holds tokens
      if (cmd.refill_pkt) begin
        ptok <= pinc_eff;
      end else if (cmd.rel && cfg.pkt_on) begin
        ptok <= ptok - 1'b1;
      end
      if (cmd.refill_byte) begin
        btok <= (btok > 0) ? binc_s : btok + binc_s;
      end else if (cmd.rel && cfg.byte_on) begin
        btok <= btok_after;
      end
      if (cmd.mark_end) begin
        ended <= 1'b1;
      end
      if (cmd.emit_eos) begin
        eos_sent <= 1'b1;
      end
    end
  end

  // Output register
  assign emit = cmd.emit_drop || cmd.emit_eos || cmd.rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_drop) begin
      result.result_kind <= shp_pkg::KIND_DROP;
      result.out_tag     <= tag;
      result.out_length  <= len;
      result.last        <= !can_rel;
    end else if (cmd.emit_eos) begin
      result.result_kind <= shp_pkg::KIND_EOS;
      result.out_tag     <= '0;
      result.out_length  <= '0;
      result.last        <= 1'b1;
    end else if (cmd.rel) begin
      result.result_kind <= shp_pkg::KIND_RELEASE;
      result.out_tag     <= rd_tag;
      result.out_length  <= rd_len;
      result.last        <= rel_last;
    end
  end

  // Status
  always_comb begin
    sts.op          = op;
    sts.full        = (count >= DEPTH_C);
    sts.empty       = (count == '0);
    sts.can_rel     = can_rel;
    sts.ended       = ended;
    sts.eos_pending = ended && !eos_sent;
    sts.slot_free   = !result_valid || result_ready;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("backlog count exceeds depth");
  a_rel_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.rel |-> (count != '0) && can_rel)
    else $error("release from empty or blocked backlog");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (emit && result_valid) |-> result_ready)
    else $error("result overwritten before taken");
  a_eos_after_end: assert property (@(posedge clk) disable iff (rst)
    eos_sent |-> ended)
    else $error("end result sent before stream ended");
`endif

endmodule
`default_nettype wire

// ===== hdl/shp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shp_ctrl: shaper controller
// Accepts one item, runs its operation, then after an arrival or tick drains
// the backlog one release per cycle while output is free; emits the end result when due.
// ----------------------------------------------------------------------------
module shp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire shp_pkg::shp_sts_t  sts,
  output shp_pkg::shp_cmd_t       cmd
);

  shp_pkg::state_t state;
  shp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      shp_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = shp_pkg::ST_EXEC;
        end
      end
      shp_pkg::ST_EXEC: begin
        case (sts.op)
          shp_pkg::OP_ARRIVE: begin
            if (!sts.full || sts.slot_free) begin
              state_next = shp_pkg::ST_DRAIN;
            end
          end
          shp_pkg::OP_END: begin
            if (sts.ended || !sts.empty || sts.slot_free) begin
              state_next = shp_pkg::ST_IDLE;
            end
          end
          default: state_next = shp_pkg::ST_DRAIN;
        endcase
      end
      shp_pkg::ST_DRAIN: begin
        if (!sts.empty && sts.can_rel) begin
          state_next = shp_pkg::ST_DRAIN;
        end else if (sts.empty && sts.eos_pending) begin
          if (sts.slot_free) begin
            state_next = shp_pkg::ST_IDLE;
          end
        end else begin
          state_next = shp_pkg::ST_IDLE;
        end
      end
      default: state_next = shp_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      shp_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      shp_pkg::ST_EXEC: begin
        case (sts.op)
          shp_pkg::OP_ARRIVE: begin
            cmd.enqueue   = !sts.full;
            cmd.emit_drop = sts.full && sts.slot_free;
          end
          shp_pkg::OP_PKT_TICK:  cmd.refill_pkt  = 1'b1;
          shp_pkg::OP_BYTE_TICK: cmd.refill_byte = 1'b1;
          shp_pkg::OP_END: begin
            if (!sts.ended) begin
              if (!sts.empty) begin
                cmd.mark_end = 1'b1;
              end else if (sts.slot_free) begin
                cmd.mark_end = 1'b1;
                cmd.emit_eos = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      shp_pkg::ST_DRAIN: begin
        if (!sts.empty && sts.can_rel) begin
          cmd.rel = sts.slot_free;
        end else if (sts.empty && sts.eos_pending) begin
          cmd.emit_eos = sts.slot_free;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state == shp_pkg::ST_EXEC))
    else $error("accepted item not executed");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.emit_drop, cmd.emit_eos, cmd.rel}) <= 1)
    else $error("two results in one cycle");
  a_exec_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == shp_pkg::ST_EXEC && sts.op != shp_pkg::OP_ARRIVE
     && sts.op != shp_pkg::OP_END) |=> (state == shp_pkg::ST_DRAIN))
    else $error("tick did not move to drain");
`endif

endmodule
`default_nettype wire

// ===== hdl/dual_token_bucket_shaper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_token_bucket_shaper: packet shaper with packet and byte token buckets
// Arrivals queue in a ring backlog (dropped when full) and leave in order
// while both enabled buckets allow; refill ticks top up the buckets; end of
// stream is reported once the backlog has emptied.
//
//   channel   signals                          direction
//   item      item_valid/item_ready/item       in   (operation, length, tag)
//   result    result_valid/result_ready/result out  (kind, tag, length, last)
//   config    psel/penable/pwrite/paddr/...    APB, 64-bit, 8-byte stride
//
// An item is accepted in the idle state and run in the execute state; one
// item at a time. An arrival or tick then drains, releasing while the output
// register is free, until the backlog is empty or blocked or the end result
// is sent. End of stream goes back to idle from execute, where drops leave.
// Synchronous reset empties the backlog and clears both buckets; no clear
// pass. A result waiting in the output register holds further results.
// ----------------------------------------------------------------------------
module dual_token_bucket_shaper #(
  parameter int BACKLOG_DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire shp_pkg::in_item_t           item,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output shp_pkg::out_item_t               result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [shp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [shp_pkg::DATA_W-1:0]  pwdata,
  output logic      [shp_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  shp_pkg::shp_cfg_t cfg;
  shp_pkg::shp_cmd_t cmd;
  shp_pkg::shp_sts_t sts;

  shp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  shp_dp #(
    .BACKLOG_DEPTH (BACKLOG_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
